// ----- rtl/core/spg_pkg.sv -----
// ============================================================================
// Sprite row pixel generator package
// Shared constants, register indexes and transaction types for the sprite
// row pixel generator and its helpers.
// ============================================================================
package spg_pkg;

    // Tile pattern memory geometry
    localparam int TILE_MEM_BYTES = 4096;
    localparam int TILE_BYTES     = 16;
    localparam int TILE_ADDR_W    = $clog2(TILE_MEM_BYTES);
    localparam int TILE_SHIFT     = $clog2(TILE_BYTES);

    // The memory is split into an even-byte bank and an odd-byte bank so that
    // both bit-plane bytes of a sprite row are read in the same cycle.
    localparam int BANK_DEPTH     = TILE_MEM_BYTES / 2;
    localparam int BANK_ADDR_W    = TILE_ADDR_W - 1;

    // Screen geometry
    localparam int SCREEN_WIDTH   = 160;
    localparam int SPRITE_COLS    = 8;
    localparam int COL_W          = $clog2(SPRITE_COLS);
    localparam logic [7:0] VISIBLE_LINES = 8'd144;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_TALL      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_PALETTE_ZERO = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_PALETTE_ONE  = 2'd2;
    localparam int CFG_DATA_W = 8;

    // Request type codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Input transaction
    typedef struct packed {
        logic        req_type;
        logic [11:0] tile_addr;
        logic [7:0]  tile_byte;
        logic [7:0]  scanline;
        logic [7:0]  sprite_y;
        logic [7:0]  sprite_x;
        logic [7:0]  tile_index;
        logic        use_palette_one;
        logic        flip_x;
        logic        flip_y;
    } spg_in_t;

    // Result transaction
    typedef struct packed {
        logic [7:0] pixel_x;
        logic [1:0] shade;
        logic       last;
    } spg_out_t;

endpackage

// ----- rtl/core/sprite_row_pixel_generator_top.sv -----
// ============================================================================
// Sprite row pixel generator
// Holds the tile pattern memory and turns one sprite entry into the visible,
// non-transparent pixels of the current scanline, left to right.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------
//   in      | input     | in_valid / in_stall  | in_data  (spg_in_t)
//   out     | output    | out_valid / out_stall| out_data (spg_out_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A tile write stores its byte in the even or odd bank at acceptance. A render
// transaction reads both bit-plane bytes from the even and odd banks at
// acceptance, builds a column mask as the fetch stage moves into the column
// emitter, then emits one pixel per cycle from the emitter while the output is
// not stalled; a sprite row gives at most eight visible pixels. The next
// transaction enters while the emitter hands off its final pixel. Reset clears
// the configuration registers and all valid state; the tile memory is
// undefined until written. An output stall holds the output register and the
// emitter, and the input stalls while the fetch stage cannot move on.
// ============================================================================
module sprite_row_pixel_generator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  spg_pkg::spg_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output spg_pkg::spg_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import spg_pkg::*;

    // Configuration registers
    logic       sprite_tall_reg;
    logic [7:0] obj_palette_zero_reg;
    logic [7:0] obj_palette_one_reg;

    // Fetch stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_sx_reg;
    logic [7:0] s1_pal_reg;
    logic       s1_flip_x_reg;

    // Column emitter
    logic [SPRITE_COLS-1:0]      em_mask_reg;
    logic [SPRITE_COLS-1:0]      em_mask_next;
    logic [SPRITE_COLS-1:0][1:0] em_shade_reg;
    logic [7:0]                  em_sx_reg;

    // Output register
    logic     out_valid_reg;
    logic     out_valid_next;
    spg_out_t out_data_reg;

    // Handshake and control
    logic in_accept;
    logic render_hit;
    logic s1_move;
    logic em_valid;
    logic em_pop;
    logic em_free;

    // Row address calculation
    logic [7:0]             line_diff;
    logic                   in_height;
    logic [3:0]             row_raw;
    logic [3:0]             row_sel;
    logic [7:0]             tile_sel;
    logic [TILE_ADDR_W-1:0] row_base;
    logic [TILE_ADDR_W-1:0] wr_addr;

    // Bank interfaces
    logic       we_even;
    logic       we_odd;
    logic       rd_en;
    logic [7:0] plane_lo;
    logic [7:0] plane_hi;

    // Column decode and selection
    logic [SPRITE_COLS-1:0]      new_mask;
    logic [SPRITE_COLS-1:0][1:0] new_shade;
    logic [SPRITE_COLS-1:0]      em_onehot;
    logic [SPRITE_COLS-1:0]      em_rest;
    logic [COL_W-1:0]            em_sel;

    // Transaction handshakes
    assign in_accept = in_valid && !in_stall;
    assign em_valid  = |em_mask_reg;
    assign em_pop    = em_valid && (!out_valid_reg || !out_stall);
    assign em_free   = !em_valid || (em_pop && (em_rest == '0));
    assign s1_move   = s1_valid_reg && em_free;
    assign in_stall  = s1_valid_reg && !em_free;

    // Scanline hit test and row selection with vertical flip
    assign line_diff = in_data.scanline - in_data.sprite_y;
    assign in_height = sprite_tall_reg ? (line_diff[7:4] == 4'd0) : (line_diff[7:3] == 5'd0);
    assign render_hit = (in_data.req_type == REQ_RENDER)
                        && (in_data.scanline < VISIBLE_LINES)
                        && (in_data.scanline >= in_data.sprite_y)
                        && in_height;
    assign row_raw = line_diff[3:0];

    always_comb
    begin
        row_sel = row_raw;
        if (in_data.flip_y)
        begin
            row_sel = sprite_tall_reg ? ~row_raw : {1'b0, ~row_raw[2:0]};
        end
    end

    // Tall sprites ignore the low tile index bit
    assign tile_sel = sprite_tall_reg ? {in_data.tile_index[7:1], 1'b0} : in_data.tile_index;
    assign row_base = TILE_ADDR_W'({tile_sel, {TILE_SHIFT{1'b0}}})
                      + TILE_ADDR_W'({row_sel, 1'b0});
    assign wr_addr  = TILE_ADDR_W'(in_data.tile_addr);

    // Bank write and read enables
    assign we_even = in_accept && (in_data.req_type == REQ_WRITE) && !wr_addr[0];
    assign we_odd  = in_accept && (in_data.req_type == REQ_WRITE) && wr_addr[0];
    assign rd_en   = in_accept && render_hit;

    spg_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_even (
        .clk   (clk),
        .we    (we_even),
        .waddr (wr_addr[TILE_ADDR_W-1:1]),
        .wdata (in_data.tile_byte),
        .re    (rd_en),
        .raddr (row_base[TILE_ADDR_W-1:1]),
        .rdata (plane_lo)
    );

    spg_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_bank_odd (
        .clk   (clk),
        .we    (we_odd),
        .waddr (wr_addr[TILE_ADDR_W-1:1]),
        .wdata (in_data.tile_byte),
        .re    (rd_en),
        .raddr (row_base[TILE_ADDR_W-1:1]),
        .rdata (plane_hi)
    );

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_tall_reg      <= 1'b0;
            obj_palette_zero_reg <= 8'd0;
            obj_palette_one_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPRITE_TALL:      sprite_tall_reg      <= cfg_data[0];
                CFG_OBJ_PALETTE_ZERO: obj_palette_zero_reg <= cfg_data[7:0];
                CFG_OBJ_PALETTE_ONE:  obj_palette_one_reg  <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Fetch stage: holds the sprite context while the banks are read
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = render_hit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_sx_reg     <= in_data.sprite_x;
            s1_pal_reg    <= in_data.use_palette_one ? obj_palette_one_reg
                                                     : obj_palette_zero_reg;
            s1_flip_x_reg <= in_data.flip_x;
        end
    end

    // Column decode: colour index, on-screen test and palette shade per column
    always_comb
    begin : col_decode
        logic [8:0]       col_x;
        logic [COL_W-1:0] bit_sel;
        logic [1:0]       idx;
        for (int c = 0; c < SPRITE_COLS; c++)
        begin
            col_x   = {1'b0, s1_sx_reg} + 9'(c);
            bit_sel = s1_flip_x_reg ? COL_W'(c) : COL_W'(SPRITE_COLS - 1 - c);
            idx     = {plane_hi[bit_sel], plane_lo[bit_sel]};
            new_mask[c]  = (idx != 2'd0) && (col_x < 9'(SCREEN_WIDTH));
            new_shade[c] = s1_pal_reg[{idx, 1'b0} +: 2];
        end
    end

    // Pick the leftmost remaining column
    assign em_onehot = em_mask_reg & (~em_mask_reg + SPRITE_COLS'(1));
    assign em_rest   = em_mask_reg & ~em_onehot;

    always_comb
    begin
        em_sel = '0;
        for (int c = 0; c < SPRITE_COLS; c++)
        begin
            if (em_onehot[c])
            begin
                em_sel = em_sel | COL_W'(c);
            end
        end
    end

    // Column emitter state
    always_comb
    begin
        em_mask_next = em_mask_reg;
        if (s1_move)
        begin
            em_mask_next = new_mask;
        end
        else if (em_pop)
        begin
            em_mask_next = em_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_mask_reg <= '0;
        end
        else
        begin
            em_mask_reg <= em_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            em_shade_reg <= new_shade;
            em_sx_reg    <= s1_sx_reg;
        end
    end

    // Output register
    assign out_valid_next = em_pop || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_pop)
        begin
            out_data_reg.pixel_x <= em_sx_reg + 8'(em_sel);
            out_data_reg.shade   <= em_shade_reg[em_sel];
            out_data_reg.last    <= (em_rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/spg_ram.sv -----
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data. The read data
// register only updates when a read is enabled.
// ============================================================================
module spg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/spg_checker.sv -----
// ============================================================================
// Sprite row pixel generator port checker
// Watches the top-level ports for output hold, column range and input stall
// behavior, and is bound to the top level.
// ============================================================================
module spg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input spg_pkg::spg_in_t  in_data,
    input logic              out_valid,
    input logic              out_stall,
    input spg_pkg::spg_out_t out_data
);

    import spg_pkg::*;

    // A stalled result transaction stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

    // Emitted columns always lie on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.pixel_x < 8'(SCREEN_WIDTH)))
    else $error("pixel column beyond screen width");

    // The input only stalls behind a sprite accepted earlier
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(in_valid && !in_stall) || $past(in_stall))
    else $error("input stalled with no sprite in flight");

    // A stall begins only right after a render transaction is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall && in_data.req_type == REQ_RENDER))
    else $error("input stall began without a render transaction");

endmodule

bind sprite_row_pixel_generator_top spg_checker u_spg_checker (.*);

// ----- sim/tb.sv -----
// ============================================================================
// Sprite row pixel generator testbench
// Fills the tile pattern memory through write transactions and renders sprite
// rows under several register settings. A predictor built into the bench
// works out the pixels that every accepted render transaction should produce,
// and the monitor compares each emitted pixel with the oldest prediction.
// Both channels insert random idle cycles and stalls.
// ============================================================================
`timescale 1ns / 100ps

module tb;

    import spg_pkg::*;

    // The configuration port has one index with no register behind it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Cycles allowed after the last pixel for transactions that emit nothing.
    localparam int SETTLE_CYCLES = 20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    spg_in_t                in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    spg_out_t               out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register shadows, updated only while the block is idle.
    logic       tall_sprites = 1'b0;
    logic [7:0] palette_zero = 8'h00;
    logic [7:0] palette_one  = 8'h00;

    // Tile memory as seen by accepted transactions, and the bytes that the
    // stimulus has already scheduled a write for.
    logic [7:0] tile_shadow    [TILE_MEM_BYTES];
    bit         byte_scheduled [TILE_MEM_BYTES];

    spg_in_t  pending_items[$];
    spg_out_t expected_pixels[$];

    int items_queued    = 0;
    int items_accepted  = 0;
    int tile_writes     = 0;
    int sprite_renders  = 0;
    int pixels_checked  = 0;
    int register_writes = 0;
    int error_count     = 0;
    int send_idle_max   = 0;
    int recv_idle_max   = 0;
    int send_gap;
    int recv_wait;
    spg_out_t pixel_want;

    sprite_row_pixel_generator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Memory address of the first bit-plane byte that a render transaction
    // reads, or -1 when the scanline misses the sprite or lies off screen.
    function automatic int row_base(input spg_in_t item);
        int unsigned height;
        int unsigned row;
        logic [7:0]  tile;
        height = tall_sprites ? 16 : 8;
        if (item.req_type != REQ_RENDER || item.scanline >= VISIBLE_LINES ||
            item.scanline < item.sprite_y || item.scanline >= item.sprite_y + height)
            return -1;
        row = item.scanline - item.sprite_y;
        if (item.flip_y)
            row = height - 1 - row;
        // Tall sprites always start on an even tile.
        tile = tall_sprites ? {item.tile_index[7:1], 1'b0} : item.tile_index;
        return (tile * TILE_BYTES + row * 2) % TILE_MEM_BYTES;
    endfunction

    // Applies one accepted transaction to the shadow memory and queues the
    // pixels that a render transaction should emit.
    function automatic void render_sprite_row(input spg_in_t item);
        int               base;
        int               col;
        int               column;
        logic [COL_W-1:0] plane_bit;
        int               emitted;
        logic [7:0]       plane_lo;
        logic [7:0]       plane_hi;
        logic [7:0]       palette;
        logic [1:0]       colour;
        spg_out_t         pixel;
        if (item.req_type == REQ_WRITE)
        begin
            tile_shadow[item.tile_addr] = item.tile_byte;
            tile_writes++;
            return;
        end
        sprite_renders++;
        base = row_base(item);
        if (base < 0)
            return;
        plane_lo = tile_shadow[TILE_ADDR_W'(base)];
        plane_hi = tile_shadow[TILE_ADDR_W'(base + 1)];
        palette  = item.use_palette_one ? palette_one : palette_zero;
        emitted  = 0;
        for (col = 0; col < SPRITE_COLS; col++)
        begin
            column = item.sprite_x + col;
            if (column >= SCREEN_WIDTH)
                continue;
            // Bit 7 is the leftmost column unless the sprite is mirrored.
            plane_bit = item.flip_x ? COL_W'(col) : COL_W'(SPRITE_COLS - 1 - col);
            colour = {plane_hi[plane_bit], plane_lo[plane_bit]};
            if (colour == 2'd0)
                continue;
            pixel.pixel_x = column[7:0];
            pixel.shade   = palette[{colour, 1'b0} +: 2];
            pixel.last    = 1'b0;
            expected_pixels.push_back(pixel);
            emitted++;
        end
        if (emitted > 0)
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    // Random content in every field, so that ignored fields toggle too.
    function automatic spg_in_t random_item();
        return spg_in_t'({$urandom(), $urandom()});
    endfunction

    function automatic void queue_tile_write(input logic [11:0] addr, input logic [7:0] value);
        spg_in_t item;
        item           = random_item();
        item.req_type  = REQ_WRITE;
        item.tile_addr = addr;
        item.tile_byte = value;
        byte_scheduled[addr] = 1'b1;
        pending_items.push_back(item);
        items_queued++;
    endfunction

    // Queues a render transaction, preceded by writes of any row bytes that
    // would otherwise be read before ever being written.
    function automatic void queue_render(input logic [7:0] line, sy, sx, tile,
                                         input logic pal_one, mirror_x, mirror_y);
        spg_in_t item;
        int      base;
        int      k;
        item                 = random_item();
        item.req_type        = REQ_RENDER;
        item.scanline        = line;
        item.sprite_y        = sy;
        item.sprite_x        = sx;
        item.tile_index      = tile;
        item.use_palette_one = pal_one;
        item.flip_x          = mirror_x;
        item.flip_y          = mirror_y;
        base = row_base(item);
        if (base >= 0)
        begin
            for (k = 0; k < 2; k++)
            begin
                if (!byte_scheduled[TILE_ADDR_W'(base + k)])
                    queue_tile_write(TILE_ADDR_W'(base + k), 8'($urandom_range(0, 255)));
            end
        end
        pending_items.push_back(item);
        items_queued++;
    endfunction

    // Mostly renders that hit the sprite, with random writes and random
    // misses mixed in, until the total number of queued items reaches target.
    function automatic void random_traffic(input int target);
        int pick;
        int line;
        int height;
        int row_max;
        int sx;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                queue_tile_write(TILE_ADDR_W'($urandom_range(0, TILE_MEM_BYTES - 1)),
                                 8'($urandom_range(0, 255)));
            else if (pick < 85)
            begin
                height  = tall_sprites ? 16 : 8;
                line    = $urandom_range(0, VISIBLE_LINES - 1);
                row_max = (line < height - 1) ? line : height - 1;
                // Some sprites straddle or pass the right screen edge.
                if ($urandom_range(0, 4) == 0)
                    sx = $urandom_range(SCREEN_WIDTH - SPRITE_COLS, 255);
                else
                    sx = $urandom_range(0, SCREEN_WIDTH - 1);
                queue_render(8'(line), 8'(line - $urandom_range(0, row_max)), 8'(sx),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
                queue_render(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
        end
    endfunction

    // Register write through the configuration port; the block is idle.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_SPRITE_TALL:      tall_sprites = value[0];
            CFG_OBJ_PALETTE_ZERO: palette_zero = value;
            CFG_OBJ_PALETTE_ONE:  palette_one  = value;
            default: ;
        endcase
        register_writes++;
    endtask

    // Waits until every queued transaction is accepted, every predicted
    // pixel has arrived, and the block has had time to finish silent work.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: presents queued transactions with random idle gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                render_sprite_row(in_data);
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap = $urandom_range(0, send_idle_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each accepted pixel and draws the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected pixel x=%0d shade=%0d last=%0b",
                             $time, out_data.pixel_x, out_data.shade, out_data.last);
                end
                else
                begin
                    pixel_want = expected_pixels.pop_front();
                    if (out_data.pixel_x !== pixel_want.pixel_x ||
                        out_data.shade !== pixel_want.shade ||
                        out_data.last !== pixel_want.last)
                    begin
                        error_count++;
                        // Each value is shown as column/shade/last.
                        $display("%0t: pixel mismatch, expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                                 $time, pixel_want.pixel_x, pixel_want.shade, pixel_want.last,
                                 out_data.pixel_x, out_data.shade, out_data.last);
                    end
                end
                pixels_checked++;
                recv_wait = $urandom_range(0, recv_idle_max);
            end
            else if (recv_wait > 0)
                recv_wait--;
            out_stall <= (recv_wait > 0);
        end
    end

    // Stimulus sequence: directed checks, then random phases.
    initial
    begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Short sprites with two distinct palettes.
        send_idle_max = 4;
        recv_idle_max = 4;
        write_register(CFG_SPRITE_TALL, 8'h00);
        write_register(CFG_OBJ_PALETTE_ZERO, 8'hE4);
        write_register(CFG_OBJ_PALETTE_ONE, 8'h1B);
        write_register(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
        queue_tile_write(12'h000, 8'h0F);
        queue_tile_write(12'h001, 8'h33);
        queue_render(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
        // Right screen edge: partly and fully off screen.
        queue_render(8'd0, 8'd0, 8'd156, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd7, 8'd0, 8'd40, 8'd255, 1'b0, 1'b0, 1'b1);
        queue_tile_write(12'hFFE, 8'hFF);
        queue_tile_write(12'hFFF, 8'hFF);
        queue_render(8'd143, 8'd136, 8'd152, 8'd255, 1'b1, 1'b1, 1'b0);
        // A fully transparent row emits nothing.
        queue_tile_write(12'h010, 8'h00);
        queue_tile_write(12'h011, 8'h00);
        queue_render(8'd0, 8'd0, 8'd20, 8'd1, 1'b0, 1'b0, 1'b0);
        // Scanline misses: off screen, above the sprite, below it.
        queue_render(8'd144, 8'd140, 8'd10, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd255, 8'd250, 8'd10, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd3, 8'd255, 8'd10, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_render(8'd8, 8'd0, 8'd10, 8'd0, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // Tall sprites, extreme palettes, with upper data bits set.
        send_idle_max = 0;
        recv_idle_max = 0;
        write_register(CFG_SPRITE_TALL, 8'hFF);
        write_register(CFG_OBJ_PALETTE_ZERO, 8'hFF);
        write_register(CFG_OBJ_PALETTE_ONE, 8'h00);
        queue_render(8'd15, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
        queue_render(8'd15, 8'd0, 8'd8, 8'd255, 1'b0, 1'b1, 1'b1);
        queue_render(8'd20, 8'd10, 8'd60, 8'd1, 1'b0, 1'b0, 1'b0);
        queue_render(8'd16, 8'd0, 8'd60, 8'd2, 1'b0, 1'b0, 1'b0);
        queue_render(8'd143, 8'd128, 8'd0, 8'd16, 1'b1, 1'b1, 1'b1);
        wait_idle();

        // Random phases under varying registers and back-pressure.
        for (phase = 0; phase < 5; phase++)
        begin
            send_idle_max = (phase == 1 || phase == 3) ? 0 : 4;
            recv_idle_max = (phase == 1 || phase == 2) ? 0 : 4;
            write_register(CFG_SPRITE_TALL,
                           (phase < 4) ? {7'($urandom_range(0, 127)), phase[0]}
                                       : 8'($urandom_range(0, 255)));
            write_register(CFG_OBJ_PALETTE_ZERO, 8'($urandom_range(0, 255)));
            write_register(CFG_OBJ_PALETTE_ONE, 8'($urandom_range(0, 255)));
            write_register(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
            random_traffic(items_queued + 57);
            wait_idle();
        end

        $display("Ran %0d tile writes and %0d sprite renders over %0d register writes.",
                 tile_writes, sprite_renders, register_writes);
        $display("Compared %0d pixels, %0d mismatches.", pixels_checked, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
